// ===== hdl/bdgd_pkg.sv =====
package bdgd_pkg;

  localparam int TickWidthDefault = 16;
  localparam int CfgWidth         = 16;
  localparam int CfgIndexWidth    = 3;

  // Register indexes on the configuration port
  localparam logic [CfgIndexWidth-1:0] REG_DEBOUNCE     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_QUIET        = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SHORT_MAX    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_MIN     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_LONG_MAX     = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_AGE_LIMIT    = 3'd5;

  // Reset values of the registers
  localparam logic [CfgWidth-1:0] DebounceReset  = 16'd20;
  localparam logic [CfgWidth-1:0] QuietReset     = 16'd501;
  localparam logic [CfgWidth-1:0] ShortMaxReset  = 16'd300;
  localparam logic [CfgWidth-1:0] LongMinReset   = 16'd600;
  localparam logic [CfgWidth-1:0] LongMaxReset   = 16'd2000;
  localparam logic [CfgWidth-1:0] AgeLimitReset  = 16'd4000;

  // Final step of each matcher
  localparam int SingleLast = 2;
  localparam int DoubleLast = 4;
  localparam int LongLast   = 2;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic        raw_pressed;
    logic [15:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0] gesture;
    logic       stable_pressed;
  } out_item_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] quiet_release_ticks;
    logic [CfgWidth-1:0] short_max_ticks;
    logic [CfgWidth-1:0] long_min_ticks;
    logic [CfgWidth-1:0] long_max_ticks;
    logic [CfgWidth-1:0] age_limit_ticks;
  } cfg_t;

endpackage

// ===== hdl/bdgd_debounce.sv =====
module bdgd_debounce #(
  parameter int TICK_WIDTH = bdgd_pkg::TickWidthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          raw,
  input  logic [TICK_WIDTH-1:0]         now,
  input  logic [bdgd_pkg::CfgWidth-1:0] debounce_ticks,
  output logic                          level_next
);

  localparam int CW = (TICK_WIDTH > bdgd_pkg::CfgWidth) ? TICK_WIDTH : bdgd_pkg::CfgWidth;

  logic                  last_raw;
  logic                  settling;
  logic                  level;
  logic [TICK_WIDTH-1:0] settle_start;

  logic                  settling_next;
  logic [TICK_WIDTH-1:0] settle_start_next;
  logic [TICK_WIDTH-1:0] held;

  always_comb begin
    held              = now - settle_start;
    settling_next     = settling;
    settle_start_next = settle_start;
    level_next        = level;
    if (raw != last_raw) begin
      settle_start_next = now;
      settling_next     = 1'b1;
    end else if (settling) begin
      if (CW'(held) > CW'(debounce_ticks)) begin
        settling_next = 1'b0;
        level_next    = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      settling     <= 1'b0;
      level        <= 1'b0;
      settle_start <= '0;
    end else if (en) begin
      last_raw     <= raw;
      settling     <= settling_next;
      level        <= level_next;
      settle_start <= settle_start_next;
    end
  end

endmodule

// ===== hdl/bdgd_matcher.sv =====
module bdgd_matcher #(
  parameter int TICK_WIDTH = bdgd_pkg::TickWidthDefault,
  parameter int LAST       = bdgd_pkg::SingleLast,
  parameter bit IS_LONG    = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  bdgd_pkg::cfg_t cfg,
  input  logic [((TICK_WIDTH > bdgd_pkg::CfgWidth) ? TICK_WIDTH : bdgd_pkg::CfgWidth)-1:0] age,
  input  logic           cur,
  input  logic           prev,
  output logic           fire
);

  localparam int CW = (TICK_WIDTH > bdgd_pkg::CfgWidth) ? TICK_WIDTH : bdgd_pkg::CfgWidth;
  localparam int SW = $clog2(LAST + 1);
  localparam logic [SW-1:0] LastStep = SW'(LAST);

  logic [SW-1:0] step;
  logic [SW-1:0] step_next;
  logic [SW-1:0] s;
  logic [CW-1:0] lim_min;
  logic [CW-1:0] lim_max;
  logic          is_final;
  logic          ok;

  always_comb begin
    s = (step > LastStep) ? '0 : step;

    // limits of the phase that is ending
    lim_min  = CW'(cfg.quiet_release_ticks);
    lim_max  = '0;
    is_final = 1'b0;
    if (s == '0) begin
      is_final = 1'b0;
    end else if (s == LastStep) begin
      is_final = 1'b1;
    end else if (IS_LONG) begin
      lim_min = CW'(cfg.long_min_ticks);
      lim_max = CW'(cfg.long_max_ticks);
    end else begin
      lim_min = '0;
      lim_max = CW'(cfg.short_max_ticks);
    end

    ok        = (lim_min <= age) && ((lim_max == '0) || (lim_max >= age));
    step_next = s;
    fire      = 1'b0;
    if (cur != prev) begin
      if (cur || (s != '0)) begin
        // a press past the final step restarts
        step_next = (ok && (s < LastStep)) ? s + SW'(1) : '0;
      end
    end else if (!cur && (s != '0) && is_final && (age >= lim_min)) begin
      step_next = '0;
      fire      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (en) begin
      step <= step_next;
    end
  end

endmodule

// ===== hdl/button_debounce_gesture_detect_core.sv =====
// Button debounce and gesture detector. Each input item is one poll of a push
// button (raw level plus a wrapping tick timestamp) and yields exactly one
// result item: the debounced level after the poll and a gesture code (none,
// single click, double click, long press; long beats double beats single).
// Items pass through an input register and a result register with the whole
// debounce and matcher update in between, so one item is taken per clock
// unless the input stalls; a result is registered as its item leaves the
// input register. A stalled result holds the input register, so the input
// stalls only while the result register is full and stalled. Timing follows
// the timestamps only, never the clock or the poll rate. The user must write
// registers via cfg_we/cfg_index/cfg_data only while no item is in flight (not
// enforced by the block); indexes past the last register are ignored.
module button_debounce_gesture_detect_core #(
  parameter int TICK_WIDTH = bdgd_pkg::TickWidthDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bdgd_pkg::in_item_t                 in_item,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output bdgd_pkg::out_item_t                out_item,
  // register writes
  input  logic                               cfg_we,
  input  logic [bdgd_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bdgd_pkg::CfgWidth-1:0]      cfg_data
);

  localparam int CW = (TICK_WIDTH > bdgd_pkg::CfgWidth) ? TICK_WIDTH : bdgd_pkg::CfgWidth;

  // configuration registers
  bdgd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= bdgd_pkg::DebounceReset;
      cfg.quiet_release_ticks <= bdgd_pkg::QuietReset;
      cfg.short_max_ticks     <= bdgd_pkg::ShortMaxReset;
      cfg.long_min_ticks      <= bdgd_pkg::LongMinReset;
      cfg.long_max_ticks      <= bdgd_pkg::LongMaxReset;
      cfg.age_limit_ticks     <= bdgd_pkg::AgeLimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        bdgd_pkg::REG_DEBOUNCE:  cfg.debounce_ticks      <= cfg_data;
        bdgd_pkg::REG_QUIET:     cfg.quiet_release_ticks <= cfg_data;
        bdgd_pkg::REG_SHORT_MAX: cfg.short_max_ticks     <= cfg_data;
        bdgd_pkg::REG_LONG_MIN:  cfg.long_min_ticks      <= cfg_data;
        bdgd_pkg::REG_LONG_MAX:  cfg.long_max_ticks      <= cfg_data;
        bdgd_pkg::REG_AGE_LIMIT: cfg.age_limit_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register; it advances whenever the result register is free or drains
  logic               in_q_valid;
  bdgd_pkg::in_item_t in_q;
  logic               adv;

  assign adv      = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_item;
    end
  end

  // timestamp taken modulo 2^TICK_WIDTH
  logic [CW-1:0]         now_cw;
  logic [TICK_WIDTH-1:0] now;
  assign now_cw = CW'(in_q.now_ticks);
  assign now    = TICK_WIDTH'(now_cw);

  // debounce
  logic cur;

  bdgd_debounce #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_debounce (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .raw            (in_q.raw_pressed),
    .now            (now),
    .debounce_ticks (cfg.debounce_ticks),
    .level_next     (cur)
  );

  // edge timing
  logic                  last_debounced;
  logic [TICK_WIDTH-1:0] last_edge_time;
  logic [TICK_WIDTH-1:0] last_edge_time_next;
  logic [TICK_WIDTH-1:0] age;
  logic [CW-1:0]         age_cw;

  assign age    = now - last_edge_time;
  assign age_cw = CW'(age);

  always_comb begin
    last_edge_time_next = last_edge_time;
    if (cur != last_debounced) begin
      last_edge_time_next = now;
    end else if (age_cw > CW'(cfg.age_limit_ticks)) begin
      // saturate the age; matchers still saw the full age this poll
      last_edge_time_next = TICK_WIDTH'(now_cw - CW'(cfg.age_limit_ticks));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_debounced <= 1'b0;
      last_edge_time <= '0;
    end else if (adv) begin
      last_debounced <= cur;
      last_edge_time <= last_edge_time_next;
    end
  end

  // three matchers in parallel
  logic fire_single;
  logic fire_double;
  logic fire_long;

  bdgd_matcher #(
    .TICK_WIDTH (TICK_WIDTH),
    .LAST       (bdgd_pkg::SingleLast),
    .IS_LONG    (1'b0)
  ) u_single (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .cfg  (cfg),
    .age  (age_cw),
    .cur  (cur),
    .prev (last_debounced),
    .fire (fire_single)
  );

  bdgd_matcher #(
    .TICK_WIDTH (TICK_WIDTH),
    .LAST       (bdgd_pkg::DoubleLast),
    .IS_LONG    (1'b0)
  ) u_double (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .cfg  (cfg),
    .age  (age_cw),
    .cur  (cur),
    .prev (last_debounced),
    .fire (fire_double)
  );

  bdgd_matcher #(
    .TICK_WIDTH (TICK_WIDTH),
    .LAST       (bdgd_pkg::LongLast),
    .IS_LONG    (1'b1)
  ) u_long (
    .clk  (clk),
    .rst  (rst),
    .en   (adv),
    .cfg  (cfg),
    .age  (age_cw),
    .cur  (cur),
    .prev (last_debounced),
    .fire (fire_long)
  );

  // priority: long, then double, then single
  bdgd_pkg::gesture_t gesture;

  always_comb begin
    if (fire_long) begin
      gesture = bdgd_pkg::GEST_LONG;
    end else if (fire_double) begin
      gesture = bdgd_pkg::GEST_DOUBLE;
    end else if (fire_single) begin
      gesture = bdgd_pkg::GEST_SINGLE;
    end else begin
      gesture = bdgd_pkg::GEST_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.gesture        <= gesture;
      out_item.stable_pressed <= cur;
    end
  end

endmodule
